[hw/rtl/pot_pkg.sv]
// ----------------------------------------------------------------------------
// Page occupancy tracker package
// Shared widths, reset values, command codes, state codes and helpers.
// ----------------------------------------------------------------------------
package pot_pkg;

    localparam int ADDR_W          = 48;
    localparam int SIZE_W          = 32;
    localparam int CMD_W           = 2;
    localparam int CNT_W           = 24;
    localparam int USED_W          = 13;
    localparam int PAGE_SHIFT      = 12;
    localparam int PAGE_BYTES      = 4096;
    localparam int PAGE_NUM_W      = 10;
    localparam int PAGES_PER_RANGE = 1024;
    localparam int RNG_NUM_W       = 3;
    localparam int REG_COUNT       = 8;
    localparam int REG_IDX_W       = 3;
    localparam int IN_DATA_W       = 88;
    localparam int OUT_DATA_W      = 32;
    localparam int WALK_CNT_W      = 21;

    localparam logic [ADDR_W-1:0] BASE_RESET [REG_COUNT] = '{
        48'h0800_0000_0000, 48'h0100_0000_0000, 48'h0A00_0000_0000,
        48'h1200_0000_0000, 48'h1400_0000_0000, 48'h5600_0000_0000,
        48'h7F00_0000_0000, 48'h5500_0000_0000
    };

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_QUERY = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_LOOKUP,
        S_RD_FIRST,
        S_UPD_FIRST,
        S_FILL,
        S_RD_LAST,
        S_UPD_LAST,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                  hit;
        logic [RNG_NUM_W-1:0]  rng;
        logic [PAGE_NUM_W-1:0] page;
    } t_match;

    function automatic logic [CNT_W-1:0] sat_add(
        input logic [CNT_W-1:0]  cnt,
        input logic [USED_W-1:0] mag,
        input logic              neg
    );
        logic signed [CNT_W:0] d;
        logic signed [CNT_W:0] s;
        logic [CNT_W-1:0]      r;
        d = signed'({{(CNT_W+1-USED_W){1'b0}}, mag});
        if (neg) begin
            d = -d;
        end
        s = signed'({cnt[CNT_W-1], cnt}) + d;
        if (s[CNT_W] != s[CNT_W-1]) begin
            r = s[CNT_W] ? {1'b1, {(CNT_W-1){1'b0}}} : {1'b0, {(CNT_W-1){1'b1}}};
        end else begin
            r = s[CNT_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [USED_W-1:0] clamp_used(input logic [CNT_W-1:0] cnt);
        logic [USED_W-1:0] r;
        if (cnt[CNT_W-1]) begin
            r = '0;
        end else if (cnt > CNT_W'(PAGE_BYTES)) begin
            r = USED_W'(PAGE_BYTES);
        end else begin
            r = cnt[USED_W-1:0];
        end
        return r;
    endfunction

endpackage

[hw/rtl/page_occupancy_tracker_top.sv]
// ----------------------------------------------------------------------------
// Page occupancy tracker
// Shadow map of used bytes per page, kept in one counter memory.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request: cmd, address and size. m_axis returns one
//   result per request: in_range, range_number, page_number, used_bytes.
//   The cfg port writes range base registers at any edge with i_cfg_we.
//   Counters live in a single-port-write, registered-read memory of
//   RANGE_COUNT * 1024 entries. One request is in work at a time and
//   s_axis_tready rises together with m_axis_tvalid as the result is
//   loaded, so a new request is taken only once the last result is in
//   the output register. After reset the block sweeps all RANGE_COUNT *
//   1024 entries (8192 by default) to zero, and holds s_axis_tready low
//   meanwhile.
//   A finished result waits in the output register while m_axis_tready is
//   low; the next request is accepted meanwhile and stalls only when its
//   own result is ready.
// ----------------------------------------------------------------------------
module page_occupancy_tracker_top #(
    parameter int RANGE_COUNT = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // cmd[1:0], address[49:2], size[81:50], zero fill
    input  logic [pot_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // in_range[0], range_number[3:1], page_number[13:4], used_bytes[26:14], zero fill
    output logic [pot_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [pot_pkg::REG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pot_pkg::ADDR_W-1:0]        i_cfg_data
);
    import pot_pkg::*;

    localparam int RW    = (RANGE_COUNT > 1) ? $clog2(RANGE_COUNT) : 1;
    localparam int AW    = RW + PAGE_NUM_W;
    localparam int DEPTH = RANGE_COUNT * PAGES_PER_RANGE;

    t_state                r_state;
    t_state                n_state;
    logic [ADDR_W-1:0]     r_base [REG_COUNT];
    logic [AW-1:0]         r_init_addr;

    t_cmd                  r_cmd;
    logic [ADDR_W-1:0]     r_addr;
    logic [SIZE_W-1:0]     r_size;
    logic                  r_hit;
    logic [RNG_NUM_W-1:0]  r_rng;
    logic [PAGE_NUM_W-1:0] r_pg;
    logic [USED_W-1:0]     r_first;
    logic [USED_W-1:0]     r_used;
    logic [PAGE_SHIFT-1:0] r_tail;
    logic [PAGE_NUM_W:0]   r_page;
    logic [WALK_CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0]      r_fill_val;
    logic                  r_modify;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [CNT_W-1:0]      mem [DEPTH];
    logic [CNT_W-1:0]      r_rdata;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [CNT_W-1:0]      mem_wdata;
    logic [AW-1:0]         mem_raddr;

    t_match                match;
    logic                  in_acc;
    logic                  out_free;
    logic                  neg;
    logic [USED_W-1:0]     first_c;
    logic [SIZE_W-1:0]     rest_c;
    logic [SIZE_W:0]       ncl_c;
    logic [CNT_W-1:0]      upd_val;

    pot_range_match #(
        .RANGE_COUNT (RANGE_COUNT)
    ) u_match (
        .i_addr  (r_addr),
        .i_base  (r_base),
        .o_match (match)
    );

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign neg      = (r_cmd == CMD_FREE);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        first_c = USED_W'(PAGE_BYTES) - {1'b0, r_addr[PAGE_SHIFT-1:0]};
        if (SIZE_W'(first_c) > r_size) begin
            first_c = r_size[USED_W-1:0];
        end
        rest_c  = r_size - SIZE_W'(r_first);
        ncl_c   = ({1'b0, r_size} + (SIZE_W+1)'(PAGE_BYTES - 1)) >> PAGE_SHIFT;
        upd_val = sat_add(r_rdata, (r_state == S_UPD_LAST) ? USED_W'(r_tail) : r_first,
                          neg);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (r_init_addr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (!match.hit) begin
                    n_state = S_DONE;
                end else if (r_size != '0 && r_cmd == CMD_CLEAR) begin
                    n_state = S_FILL;
                end else begin
                    n_state = S_RD_FIRST;
                end
            end
            S_RD_FIRST:  n_state = S_UPD_FIRST;
            S_UPD_FIRST: n_state = r_modify ? S_FILL : S_DONE;
            S_FILL: begin
                if (r_cnt == '0) begin
                    n_state = (r_tail != '0 && !r_page[PAGE_NUM_W]) ? S_RD_LAST : S_DONE;
                end else if (r_page[PAGE_NUM_W]) begin
                    n_state = S_DONE;
                end
            end
            S_RD_LAST:  n_state = S_UPD_LAST;
            S_UPD_LAST: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    // outputs
    always_comb begin
        s_axis_tready = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = {r_rng[RW-1:0], r_pg};
        mem_wdata     = upd_val;
        mem_raddr     = {r_rng[RW-1:0], r_pg};
        unique case (r_state)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = r_init_addr;
                mem_wdata = '0;
            end
            S_IDLE:      s_axis_tready = 1'b1;
            S_UPD_FIRST: mem_we = r_modify;
            S_FILL: begin
                mem_we    = (r_cnt != '0) && !r_page[PAGE_NUM_W];
                mem_waddr = {r_rng[RW-1:0], r_page[PAGE_NUM_W-1:0]};
                mem_wdata = r_fill_val;
            end
            S_RD_LAST: mem_raddr = {r_rng[RW-1:0], r_page[PAGE_NUM_W-1:0]};
            S_UPD_LAST: begin
                mem_we    = 1'b1;
                mem_waddr = {r_rng[RW-1:0], r_page[PAGE_NUM_W-1:0]};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_addr <= '0;
            r_out_valid <= 1'b0;
            r_base      <= BASE_RESET;
        end else begin
            r_state <= n_state;
            if (r_state == S_INIT) begin
                r_init_addr <= r_init_addr + AW'(1);
            end
            if (i_cfg_we) begin
                r_base[i_cfg_idx] <= i_cfg_data;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd  <= t_cmd'(s_axis_tdata[CMD_W-1:0]);
            r_addr <= s_axis_tdata[CMD_W +: ADDR_W];
            r_size <= s_axis_tdata[CMD_W+ADDR_W +: SIZE_W];
        end
        unique case (r_state)
            S_LOOKUP: begin
                r_hit      <= match.hit;
                r_rng      <= match.rng;
                r_pg       <= match.page;
                r_first    <= first_c;
                r_used     <= '0;
                r_page     <= {1'b0, match.page};
                r_cnt      <= ncl_c[WALK_CNT_W-1:0];
                r_tail     <= '0;
                r_fill_val <= (r_cmd == CMD_ALLOC) ? CNT_W'(PAGE_BYTES) : '0;
                r_modify   <= (r_size != '0) &&
                              (r_cmd == CMD_ALLOC || r_cmd == CMD_FREE);
            end
            S_RD_FIRST: begin
                r_page <= {1'b0, r_pg} + (PAGE_NUM_W+1)'(1);
                r_cnt  <= WALK_CNT_W'(rest_c[SIZE_W-1:PAGE_SHIFT]);
                r_tail <= rest_c[PAGE_SHIFT-1:0];
            end
            S_UPD_FIRST: begin
                r_used <= clamp_used(r_modify ? upd_val : r_rdata);
            end
            S_FILL: begin
                if (r_cnt != '0 && !r_page[PAGE_NUM_W]) begin
                    r_page <= r_page + (PAGE_NUM_W+1)'(1);
                    r_cnt  <= r_cnt - WALK_CNT_W'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    r_out_data <= OUT_DATA_W'({r_used, r_pg, r_rng, r_hit});
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTH
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !s_axis_tready)
        else $error("request accepted during memory sweep");

    a_accept_to_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_LOOKUP))
        else $error("accepted request did not start lookup");

    a_no_write_past_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL && r_page[PAGE_NUM_W]) |-> !mem_we)
        else $error("page walk wrote past range end");

    a_result_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not loaded at end of request");
`endif

endmodule

[hw/rtl/pot_range_match.sv]
// ----------------------------------------------------------------------------
// Range match
// Finds the first configured range holding an address and its page index.
// ----------------------------------------------------------------------------
module pot_range_match #(
    parameter int RANGE_COUNT = 8
) (
    input  logic [pot_pkg::ADDR_W-1:0] i_addr,
    input  logic [pot_pkg::ADDR_W-1:0] i_base [pot_pkg::REG_COUNT],
    output pot_pkg::t_match            o_match
);
    import pot_pkg::*;

    localparam int HI_W = ADDR_W - PAGE_SHIFT - PAGE_NUM_W;

    logic [ADDR_W:0] diff [RANGE_COUNT];
    logic            ok   [RANGE_COUNT];

    always_comb begin
        for (int i = 0; i < RANGE_COUNT; i++) begin
            diff[i] = {1'b0, i_addr} - {1'b0, i_base[i]};
            ok[i]   = !diff[i][ADDR_W] &&
                      (diff[i][ADDR_W-1 -: HI_W] == '0);
        end
    end

    always_comb begin
        o_match = '0;
        for (int i = RANGE_COUNT - 1; i >= 0; i--) begin
            if (ok[i]) begin
                o_match.hit  = 1'b1;
                o_match.rng  = RNG_NUM_W'(i);
                o_match.page = diff[i][PAGE_SHIFT +: PAGE_NUM_W];
            end
        end
    end

endmodule

[tb/sv/page_occupancy_tracker_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Page occupancy tracker testbench
// Streams allocate, free, clear and query requests into the tracker, keeps a
// shadow copy of the range bases and the per-page counters, and compares
// every result with the shadow's prediction, or with the table's typed result
// where a directed row gives one. A directed table comes first, then random
// traffic under several range settings, a run that stacks one counter far
// above a page and below zero, and random stalls on both streams.
module page_occupancy_tracker_top_tb;

    import pot_pkg::*;

    localparam int              SHADOW_DEPTH     = REG_COUNT * PAGES_PER_RANGE;
    localparam longint          COUNT_CEIL       = (64'sd1 <<< (CNT_W - 1)) - 1;
    localparam longint          COUNT_FLOOR      = -COUNT_CEIL - 1;
    localparam int              LONG_HOLD_CYCLES = 300;
    localparam int              SETTLE_CYCLES    = 16;
    localparam int              DRAIN_LIMIT      = 100000;
    localparam int              STACK_STEPS      = 24;
    localparam logic [ADDR_W-1:0] PG           = 48'h1000;
    localparam logic [ADDR_W-1:0] LAST_PG      = 48'h3F_F000;
    localparam logic [ADDR_W-1:0] RANGE_SPAN   = 48'h40_0000;
    localparam logic [ADDR_W-1:0] B1 = BASE_RESET[1];
    localparam logic [ADDR_W-1:0] B2 = BASE_RESET[2];
    localparam logic [ADDR_W-1:0] B3 = BASE_RESET[3];
    localparam logic [ADDR_W-1:0] B4 = BASE_RESET[4];
    localparam logic [ADDR_W-1:0] B5 = BASE_RESET[5];
    localparam logic [ADDR_W-1:0] B6 = BASE_RESET[6];
    localparam logic [ADDR_W-1:0] B7 = BASE_RESET[7];

    typedef struct packed {
        logic                  in_range;
        logic [RNG_NUM_W-1:0]  range_number;
        logic [PAGE_NUM_W-1:0] page_number;
        logic [USED_W-1:0]     used_bytes;
    } occupancy_result_t;

    typedef struct packed {
        t_cmd              cmd;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        logic              typed;
        occupancy_result_t result;
    } directed_row_t;

    localparam occupancy_result_t NO_HIT = '0;
    localparam int                DIRECTED_COUNT = 25;

    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{CMD_QUERY, BASE_RESET[0], 32'd0, 1'b1, '{1'b1, 3'd0, 10'd0, 13'd0}},
        '{CMD_QUERY, 48'h0, 32'd0, 1'b1, NO_HIT},
        '{CMD_ALLOC, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, NO_HIT},
        '{CMD_ALLOC, B1, 32'd4096, 1'b1, '{1'b1, 3'd1, 10'd0, 13'd4096}},
        '{CMD_ALLOC, B1 + 48'h1800, 32'd0, 1'b1, '{1'b1, 3'd1, 10'd1, 13'd0}},
        '{CMD_ALLOC, B1 + 48'h1800, 32'd10000, 1'b0, NO_HIT},
        '{CMD_QUERY, B1 + 48'h2000, 32'd0, 1'b0, NO_HIT},
        '{CMD_QUERY, B1 + 48'h3FFF, 32'hFFFF_FFFF, 1'b0, NO_HIT},
        '{CMD_FREE, B1 + 48'h1800, 32'd10000, 1'b0, NO_HIT},
        '{CMD_FREE, B1, 32'd100, 1'b0, NO_HIT},
        '{CMD_FREE, B2 + 48'h10, 32'd200, 1'b1, '{1'b1, 3'd2, 10'd0, 13'd0}},
        '{CMD_ALLOC, B2 + 48'h10, 32'd100, 1'b0, NO_HIT},
        '{CMD_ALLOC, B2, 32'd12288, 1'b0, NO_HIT},
        '{CMD_CLEAR, B2 + 48'h5, 32'd1, 1'b1, '{1'b1, 3'd2, 10'd0, 13'd0}},
        '{CMD_QUERY, B2 + PG, 32'd0, 1'b0, NO_HIT},
        '{CMD_ALLOC, B3 + LAST_PG + 48'h800, 32'hFFFF_FFFF, 1'b1,
          '{1'b1, 3'd3, 10'd1023, 13'd2048}},
        '{CMD_ALLOC, B4 + 48'h123, 32'hFFFF_FFFF, 1'b0, NO_HIT},
        '{CMD_QUERY, B4 + LAST_PG, 32'd0, 1'b0, NO_HIT},
        '{CMD_CLEAR, B4 + PG, 32'hFFFF_FFFF, 1'b0, NO_HIT},
        '{CMD_QUERY, B4 + LAST_PG, 32'd0, 1'b0, NO_HIT},
        '{CMD_FREE, B5 + LAST_PG + 48'hFFF, 32'hFFFF_FFFF, 1'b0, NO_HIT},
        '{CMD_QUERY, B7 + RANGE_SPAN - 48'h1, 32'd0, 1'b1, '{1'b1, 3'd7, 10'd1023, 13'd0}},
        '{CMD_QUERY, B7 + RANGE_SPAN, 32'd0, 1'b1, NO_HIT},
        '{CMD_FREE, B6 - 48'h1, 32'd4096, 1'b1, NO_HIT},
        '{CMD_CLEAR, B3 + LAST_PG, 32'hFFFF_FFFF, 1'b1, '{1'b1, 3'd3, 10'd1023, 13'd0}}
    };

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    i_cfg_we;
    logic [REG_IDX_W-1:0]    i_cfg_idx;
    logic [ADDR_W-1:0]       i_cfg_data;

    logic                    cur_typed;
    occupancy_result_t       cur_typed_result;

    logic [ADDR_W-1:0]       range_base_shadow [REG_COUNT];
    logic signed [CNT_W-1:0] page_used_shadow [SHADOW_DEPTH];
    occupancy_result_t       expected_occupancy_q [$];
    logic [ADDR_W-1:0]       bases_now [REG_COUNT];
    int                      failure_count = 0;
    logic                    gaps_on;
    logic                    sink_stalls_on;
    logic                    long_hold_request;
    int                      sink_hold_left;

    page_occupancy_tracker_top #(
        .RANGE_COUNT(REG_COUNT)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic signed [CNT_W-1:0] bump_counter(
        input logic signed [CNT_W-1:0] cnt,
        input longint                  delta
    );
        longint sum;
        sum = longint'(cnt) + delta;
        if (sum > COUNT_CEIL) begin
            sum = COUNT_CEIL;
        end
        if (sum < COUNT_FLOOR) begin
            sum = COUNT_FLOOR;
        end
        return CNT_W'(sum);
    endfunction

    function automatic void walk_pages(
        input int                    row,
        input int                    first_page,
        input logic [PAGE_SHIFT-1:0] offset,
        input logic [SIZE_W-1:0]     size,
        input logic                  subtract
    );
        longint first_part;
        longint rest;
        int     p;
        p = first_page;
        first_part = PAGE_BYTES - longint'(offset);
        if (first_part > longint'(size)) begin
            first_part = longint'(size);
        end
        page_used_shadow[row + p] = bump_counter(page_used_shadow[row + p],
                                                 subtract ? -first_part : first_part);
        rest = longint'(size) - first_part;
        while (rest >= PAGE_BYTES) begin
            p++;
            if (p >= PAGES_PER_RANGE) begin
                return;
            end
            page_used_shadow[row + p] = subtract ? '0 : CNT_W'(PAGE_BYTES);
            rest -= PAGE_BYTES;
        end
        if (rest > 0 && p + 1 < PAGES_PER_RANGE) begin
            p++;
            page_used_shadow[row + p] = bump_counter(page_used_shadow[row + p],
                                                     subtract ? -rest : rest);
        end
    endfunction

    function automatic occupancy_result_t predict_occupancy(
        input t_cmd              cmd,
        input logic [ADDR_W-1:0] addr,
        input logic [SIZE_W-1:0] size
    );
        occupancy_result_t       res;
        logic                    hit;
        int                      i;
        int                      rng;
        int                      pg;
        int                      row;
        int                      p;
        longint unsigned         rel;
        longint unsigned         pages_left;
        logic signed [CNT_W-1:0] cnt;
        res = '0;
        hit = 1'b0;
        rng = 0;
        pg  = 0;
        for (i = 0; i < REG_COUNT; i++) begin
            if (!hit && addr >= range_base_shadow[i]) begin
                rel = 64'(addr - range_base_shadow[i]) >> PAGE_SHIFT;
                if (rel < PAGES_PER_RANGE) begin
                    hit = 1'b1;
                    rng = i;
                    pg  = int'(rel);
                end
            end
        end
        if (!hit) begin
            return res;
        end
        row = rng * PAGES_PER_RANGE;
        if (size != '0) begin
            case (cmd)
                CMD_ALLOC: walk_pages(row, pg, addr[PAGE_SHIFT-1:0], size, 1'b0);
                CMD_FREE:  walk_pages(row, pg, addr[PAGE_SHIFT-1:0], size, 1'b1);
                CMD_CLEAR: begin
                    pages_left = (64'(size) + 64'(PAGE_BYTES - 1)) >> PAGE_SHIFT;
                    for (p = pg; pages_left > 0 && p < PAGES_PER_RANGE; p++) begin
                        page_used_shadow[row + p] = '0;
                        pages_left--;
                    end
                end
                default: ;
            endcase
        end
        cnt = page_used_shadow[row + pg];
        res.in_range     = 1'b1;
        res.range_number = RNG_NUM_W'(rng);
        res.page_number  = PAGE_NUM_W'(pg);
        if (cnt < 0) begin
            res.used_bytes = '0;
        end else if (cnt > PAGE_BYTES) begin
            res.used_bytes = USED_W'(PAGE_BYTES);
        end else begin
            res.used_bytes = cnt[USED_W-1:0];
        end
        return res;
    endfunction

    // Track config writes, predict each accepted request, check each result.
    always @(posedge i_clk) begin
        occupancy_result_t predicted;
        occupancy_result_t got;
        occupancy_result_t want;
        int                n;
        if (!i_rst_n) begin
            range_base_shadow = BASE_RESET;
            for (n = 0; n < SHADOW_DEPTH; n++) begin
                page_used_shadow[n] = '0;
            end
        end else begin
            if (i_cfg_we) begin
                range_base_shadow[i_cfg_idx] = i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predicted = predict_occupancy(t_cmd'(s_axis_tdata[1:0]),
                                              s_axis_tdata[49:2], s_axis_tdata[81:50]);
                expected_occupancy_q.push_back(cur_typed ? cur_typed_result : predicted);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[0], m_axis_tdata[3:1], m_axis_tdata[13:4],
                       m_axis_tdata[26:14]};
                if (expected_occupancy_q.size() == 0) begin
                    $error("result with no request pending: %h", m_axis_tdata);
                    failure_count++;
                end else begin
                    want = expected_occupancy_q.pop_front();
                    if (got.in_range !== want.in_range) begin
                        $error("in_range: expected %0d, got %0d", want.in_range, got.in_range);
                        failure_count++;
                    end
                    if (got.range_number !== want.range_number) begin
                        $error("range_number: expected %0d, got %0d",
                               want.range_number, got.range_number);
                        failure_count++;
                    end
                    if (got.page_number !== want.page_number) begin
                        $error("page_number: expected %0d, got %0d",
                               want.page_number, got.page_number);
                        failure_count++;
                    end
                    if (got.used_bytes !== want.used_bytes) begin
                        $error("used_bytes: expected %0d, got %0d",
                               want.used_bytes, got.used_bytes);
                        failure_count++;
                    end
                end
            end
        end
    end

    function automatic int idle_length();
        int r;
        r = $urandom_range(99);
        if (r < 80) begin
            return $urandom_range(3, 1);
        end else if (r < 95) begin
            return $urandom_range(12, 4);
        end
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [ADDR_W-1:0] random_base();
        logic [ADDR_W-1:0] b;
        b = {16'($urandom), $urandom};
        if ($urandom_range(1) == 1) begin
            b[PAGE_SHIFT-1:0] = '0;
        end
        return b;
    endfunction

    // Result sink: random stalls, plus one long hold-off on request.
    initial begin
        m_axis_tready  = 1'b0;
        sink_hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_left > 0) begin
                sink_hold_left--;
                m_axis_tready <= 1'b0;
            end else if (long_hold_request) begin
                long_hold_request = 1'b0;
                sink_hold_left = LONG_HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else if (sink_stalls_on && $urandom_range(99) < 30) begin
                sink_hold_left = idle_length() - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_request(
        input t_cmd              cmd,
        input logic [ADDR_W-1:0] addr,
        input logic [SIZE_W-1:0] size,
        input logic              typed,
        input occupancy_result_t typed_result,
        input int                gap
    );
        @(negedge i_clk);
        s_axis_tvalid    <= 1'b1;
        s_axis_tdata     <= {6'd0, size, addr, cmd};
        cur_typed        <= typed;
        cur_typed_result <= typed_result;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    function automatic int source_gap();
        return (gaps_on && $urandom_range(99) < 35) ? idle_length() : 0;
    endfunction

    task automatic send_random_request();
        t_cmd              cmd;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] offset;
        int                pick;
        int                k;
        int                page;
        pick = $urandom_range(99);
        cmd  = pick < 40 ? CMD_ALLOC : pick < 65 ? CMD_FREE : pick < 75 ? CMD_CLEAR : CMD_QUERY;
        k    = $urandom_range(REG_COUNT - 1);
        pick = $urandom_range(99);
        if (pick < 85) begin
            case ($urandom_range(2))
                0:       page = $urandom_range(7);
                1:       page = PAGES_PER_RANGE - 8 + $urandom_range(7);
                default: page = $urandom_range(PAGES_PER_RANGE - 1);
            endcase
            case ($urandom_range(3))
                0:       offset = '0;
                1:       offset = ADDR_W'(PAGE_BYTES - 1);
                default: offset = ADDR_W'($urandom_range(PAGE_BYTES - 1));
            endcase
            addr = bases_now[k] + (ADDR_W'(page) << PAGE_SHIFT) + offset;
        end else if (pick < 92) begin
            addr = ($urandom_range(1) == 1) ? bases_now[k] - 48'h1
                 : bases_now[k] + RANGE_SPAN + ADDR_W'($urandom_range(PAGE_BYTES - 1));
        end else begin
            addr = {16'($urandom), $urandom};
        end
        pick = $urandom_range(99);
        if (pick < 8) begin
            size = '0;
        end else if (pick < 55) begin
            size = $urandom_range(PAGE_BYTES, 1);
        end else if (pick < 80) begin
            size = $urandom_range(5 * PAGE_BYTES, PAGE_BYTES + 1);
        end else if (pick < 95) begin
            size = $urandom_range(64 * PAGE_BYTES, 1);
        end else if (pick < 98) begin
            size = $urandom;
        end else begin
            size = '1;
        end
        send_request(cmd, addr, size, 1'b0, NO_HIT, source_gap());
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_occupancy_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_ranges();
        int k;
        for (k = 0; k < REG_COUNT; k++) begin
            @(negedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= REG_IDX_W'(k);
            i_cfg_data <= bases_now[k];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int i;
        i_rst_n           = 1'b0;
        s_axis_tvalid     = 1'b0;
        s_axis_tdata      = '0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        cur_typed         = 1'b0;
        cur_typed_result  = '0;
        gaps_on           = 1'b1;
        sink_stalls_on    = 1'b1;
        long_hold_request = 1'b0;
        bases_now         = BASE_RESET;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < DIRECTED_COUNT; i++) begin
            send_request(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].addr, DIRECTED_ROWS[i].size,
                         DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].result, source_gap());
        end

        // Extreme and overlapping ranges; hold the sink while requests keep coming.
        drain_results();
        bases_now = '{48'h0, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFC0_0000, 48'h1000,
                      48'h3F_F800, random_base(), random_base(), 48'h8000_0000_0000};
        program_ranges();
        for (i = 0; i < 450; i++) begin
            if (i == 150) begin
                long_hold_request = 1'b1;
            end
            gaps_on = !(i >= 150 && i < 200);
            send_random_request();
        end

        // Random bases, some stacked on earlier ones; start with no idling at all.
        drain_results();
        for (i = 0; i < REG_COUNT; i++) begin
            bases_now[i] = (i > 0 && $urandom_range(2) == 0)
                         ? bases_now[$urandom_range(i - 1)] + ADDR_W'($urandom_range(32'h7F_FFFF))
                         : random_base();
        end
        program_ranges();
        gaps_on        = 1'b0;
        sink_stalls_on = 1'b0;
        for (i = 0; i < 450; i++) begin
            if (i == 200) begin
                gaps_on        = 1'b1;
                sink_stalls_on = 1'b1;
            end
            send_random_request();
        end

        // Reset values again; stack one counter far above a page, then below zero.
        drain_results();
        bases_now = BASE_RESET;
        program_ranges();
        gaps_on = 1'b0;
        send_request(CMD_CLEAR, bases_now[0] + 48'h1_0000, 32'd1, 1'b0, NO_HIT, 0);
        for (i = 0; i < STACK_STEPS; i++) begin
            send_request(CMD_ALLOC, bases_now[0] + 48'h1_0000, 32'd4096, 1'b0, NO_HIT, 0);
        end
        for (i = 0; i < STACK_STEPS + 1; i++) begin
            send_request(CMD_FREE, bases_now[0] + 48'h1_0000, 32'd4096, 1'b0, NO_HIT, 0);
        end
        send_request(CMD_QUERY, bases_now[0] + 48'h1_0000, 32'd0, 1'b0, NO_HIT, 0);
        gaps_on = 1'b1;
        for (i = 0; i < 674; i++) begin
            send_random_request();
        end

        drain_results();
        if (expected_occupancy_q.size() != 0) begin
            $error("%0d results never arrived", expected_occupancy_q.size());
            failure_count++;
        end
        if (failure_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #250_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
